@@ sv/elacc_pkg.sv @@
// ----------------------------------------------------------------------------
// elacc_pkg
// Shared types, constants and the microcode program of the AC cutoff
// controller.
// ----------------------------------------------------------------------------
package elacc_pkg;

	// Configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_TPS_HIGH    = 3'd0;
	localparam reg_idx_t REG_MAP_HIGH    = 3'd1;
	localparam reg_idx_t REG_RPM_LOW     = 3'd2;
	localparam reg_idx_t REG_RPM_IDLE    = 3'd3;
	localparam reg_idx_t REG_CUT_DELAY   = 3'd4;
	localparam reg_idx_t REG_REST_DELAY  = 3'd5;
	localparam reg_idx_t REG_PULSE_TMO   = 3'd6;
	localparam reg_idx_t REG_RPM_WINDOW  = 3'd7;

	localparam logic [6:0]  RST_TPS_HIGH   = 7'd70;
	localparam logic [6:0]  RST_MAP_HIGH   = 7'd75;
	localparam logic [13:0] RST_RPM_LOW    = 14'd2000;
	localparam logic [13:0] RST_RPM_IDLE   = 14'd800;
	localparam logic [15:0] RST_CUT_DELAY  = 16'd200;
	localparam logic [15:0] RST_REST_DELAY = 16'd1000;
	localparam logic [15:0] RST_PULSE_TMO  = 16'd150;
	localparam logic [9:0]  RST_RPM_WINDOW = 10'd100;

	typedef struct packed {
		logic [6:0]  tps_high_pct;
		logic [6:0]  map_high_pct;
		logic [13:0] rpm_low_limit;
		logic [13:0] rpm_idle_limit;
		logic [15:0] cutoff_delay_ms;
		logic [15:0] restore_delay_ms;
		logic [15:0] pulse_timeout_ms;
		logic [9:0]  rpm_window_ms;
	} cfg_t;

	// Arithmetic constants
	localparam logic [15:0] RPM_SCALE    = 16'd60000;
	localparam int          QUOT_W       = 32;
	localparam logic [5:0]  RPM_DIV_BITS = 6'd32;
	// Microseconds to milliseconds: multiply by ceil(2^26 / 1000) and keep the
	// bits from 26 upwards, which is exact for every 16-bit width.
	localparam logic [16:0] WID_RECIP    = 17'd67109;
	localparam int          WID_SHIFT    = 26;

	// Microcode
	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCUM,
		OP_MUL,
		OP_DIV_RPM,
		OP_DIV_STEP,
		OP_STORE_RPM,
		OP_STORE_WID,
		OP_CLEAR_EMPTY,
		OP_FINISH
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_NO_CLOSE,
		C_EMPTY,
		C_DIV_MORE,
		C_OUT_BUSY
	} cond_t;

	typedef logic [3:0] step_t;

	localparam step_t STEP_IDLE     = 4'd0;
	localparam step_t STEP_ACCUM    = 4'd1;
	localparam step_t STEP_CHECK    = 4'd2;
	localparam step_t STEP_MUL      = 4'd3;
	localparam step_t STEP_LOAD_RPM = 4'd4;
	localparam step_t STEP_ITER_RPM = 4'd5;
	localparam step_t STEP_ST_RPM   = 4'd6;
	localparam step_t STEP_ST_WID   = 4'd7;
	localparam step_t STEP_EMPTY    = 4'd8;
	localparam step_t STEP_WAIT     = 4'd9;
	localparam step_t STEP_FINISH   = 4'd10;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_t;

	// Status flags from the datapath that the jump conditions test.
	typedef struct packed {
		logic no_close;
		logic empty;
		logic div_more;
		logic out_busy;
	} stat_t;

	function automatic ctrl_t ucode(input step_t s);
		ctrl_t w;
		case (s)
			STEP_IDLE:     w = '{OP_NOP,         C_NO_INPUT, STEP_IDLE};
			STEP_ACCUM:    w = '{OP_ACCUM,       C_NEVER,    STEP_IDLE};
			STEP_CHECK:    w = '{OP_NOP,         C_NO_CLOSE, STEP_WAIT};
			STEP_MUL:      w = '{OP_MUL,         C_EMPTY,    STEP_EMPTY};
			STEP_LOAD_RPM: w = '{OP_DIV_RPM,     C_NEVER,    STEP_IDLE};
			STEP_ITER_RPM: w = '{OP_DIV_STEP,    C_DIV_MORE, STEP_ITER_RPM};
			STEP_ST_RPM:   w = '{OP_STORE_RPM,   C_NEVER,    STEP_IDLE};
			STEP_ST_WID:   w = '{OP_STORE_WID,   C_ALWAYS,   STEP_WAIT};
			STEP_EMPTY:    w = '{OP_CLEAR_EMPTY, C_NEVER,    STEP_IDLE};
			STEP_WAIT:     w = '{OP_NOP,         C_OUT_BUSY, STEP_WAIT};
			STEP_FINISH:   w = '{OP_FINISH,      C_ALWAYS,   STEP_IDLE};
			default:       w = '{OP_NOP,         C_ALWAYS,   STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

@@ sv/elacc_regs.sv @@
// ----------------------------------------------------------------------------
// elacc_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module elacc_regs (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [elacc_pkg::ADDR_W-1:0] paddr,
	input  logic [elacc_pkg::DATA_W-1:0] pwdata,
	output logic [elacc_pkg::DATA_W-1:0] prdata,
	output logic                    pready,
	output elacc_pkg::cfg_t         cfg
);
	import elacc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tps_high_pct     <= RST_TPS_HIGH;
			cfg_q.map_high_pct     <= RST_MAP_HIGH;
			cfg_q.rpm_low_limit    <= RST_RPM_LOW;
			cfg_q.rpm_idle_limit   <= RST_RPM_IDLE;
			cfg_q.cutoff_delay_ms  <= RST_CUT_DELAY;
			cfg_q.restore_delay_ms <= RST_REST_DELAY;
			cfg_q.pulse_timeout_ms <= RST_PULSE_TMO;
			cfg_q.rpm_window_ms    <= RST_RPM_WINDOW;
		end else if (wr_en) begin
			case (idx)
				REG_TPS_HIGH:   cfg_q.tps_high_pct     <= pwdata[6:0];
				REG_MAP_HIGH:   cfg_q.map_high_pct     <= pwdata[6:0];
				REG_RPM_LOW:    cfg_q.rpm_low_limit    <= pwdata[13:0];
				REG_RPM_IDLE:   cfg_q.rpm_idle_limit   <= pwdata[13:0];
				REG_CUT_DELAY:  cfg_q.cutoff_delay_ms  <= pwdata[15:0];
				REG_REST_DELAY: cfg_q.restore_delay_ms <= pwdata[15:0];
				REG_PULSE_TMO:  cfg_q.pulse_timeout_ms <= pwdata[15:0];
				REG_RPM_WINDOW: cfg_q.rpm_window_ms    <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TPS_HIGH:   prdata = DATA_W'(cfg_q.tps_high_pct);
			REG_MAP_HIGH:   prdata = DATA_W'(cfg_q.map_high_pct);
			REG_RPM_LOW:    prdata = DATA_W'(cfg_q.rpm_low_limit);
			REG_RPM_IDLE:   prdata = DATA_W'(cfg_q.rpm_idle_limit);
			REG_CUT_DELAY:  prdata = DATA_W'(cfg_q.cutoff_delay_ms);
			REG_REST_DELAY: prdata = DATA_W'(cfg_q.restore_delay_ms);
			REG_PULSE_TMO:  prdata = DATA_W'(cfg_q.pulse_timeout_ms);
			REG_RPM_WINDOW: prdata = DATA_W'(cfg_q.rpm_window_ms);
			default:        prdata = '0;
		endcase
	end

endmodule

@@ sv/elacc_div.sv @@
// ----------------------------------------------------------------------------
// elacc_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module elacc_div #(
	parameter int DEN_W = 13
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic                         div_step,
	input  logic [elacc_pkg::QUOT_W-1:0] num,
	input  logic [DEN_W-1:0]             den,
	input  logic [5:0]                   bits,
	output logic [elacc_pkg::QUOT_W-1:0] quot,
	output logic                         more
);
	import elacc_pkg::*;

	logic [QUOT_W-1:0] num_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [5:0]        cnt_q;
	logic [DEN_W:0]    shifted;
	logic [DEN_W+1:0]  diff;
	logic              borrow;

	assign shifted = {rem_q, num_q[QUOT_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};
	assign borrow  = diff[DEN_W+1];
	assign quot    = num_q;
	assign more    = cnt_q != 6'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= bits;
		end else if (div_step) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	// The numerator shifts out at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (load) begin
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (div_step) begin
			num_q <= {num_q[QUOT_W-2:0], !borrow};
			rem_q <= borrow ? shifted[DEN_W-1:0] : diff[DEN_W-1:0];
		end
	end

endmodule

@@ sv/elacc_seq.sv @@
// ----------------------------------------------------------------------------
// elacc_seq
// Step counter and microcode table with conditional jumps.
// ----------------------------------------------------------------------------
module elacc_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  elacc_pkg::stat_t  stat,
	output elacc_pkg::ctrl_t  ctrl,
	output logic              in_stall
);
	import elacc_pkg::*;

	step_t pc_q;
	step_t pc_nx;
	logic  take;

	assign ctrl     = ucode(pc_q);
	assign in_stall = pc_q != STEP_IDLE;

	always_comb begin
		case (ctrl.cond)
			C_NEVER:    take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_INPUT: take = !in_valid;
			C_NO_CLOSE: take = stat.no_close;
			C_EMPTY:    take = stat.empty;
			C_DIV_MORE: take = stat.div_more;
			C_OUT_BUSY: take = stat.out_busy;
			default:    take = 1'b1;
		endcase
		pc_nx = take ? ctrl.target : pc_q + step_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= pc_nx;
		end
	end

endmodule

@@ sv/elacc_dp.sv @@
// ----------------------------------------------------------------------------
// elacc_dp
// Datapath: window counters, RPM and width arithmetic, cutoff decision,
// relay timer and the result register.
// ----------------------------------------------------------------------------
module elacc_dp #(
	parameter int CYLINDERS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  elacc_pkg::cfg_t  cfg,
	input  elacc_pkg::ctrl_t ctrl,
	input  logic             in_fire,
	input  logic [6:0]       map_pct,
	input  logic [6:0]       tps_pct,
	input  logic [2:0]       pulses_ended,
	input  logic [15:0]      pulse_width_us,
	input  logic             out_stall,
	output elacc_pkg::stat_t stat,
	output logic             out_valid,
	output logic             relay_on,
	output logic [15:0]      engine_rpm,
	output logic [6:0]       pulse_width_ms,
	output logic             cutoff_request
);
	import elacc_pkg::*;

	localparam int DEN_MAX = 1023 * CYLINDERS / 2;
	localparam int DEN_W   = $clog2(DEN_MAX + 1);

	// Latched input item
	logic [6:0]  map_in_q;
	logic [6:0]  tps_in_q;
	logic [2:0]  pulses_in_q;
	logic [15:0] width_in_q;

	// Controller state
	logic [9:0]  elapsed_q;
	logic [15:0] count_q;
	logic [15:0] width_us_q;
	logic [15:0] since_q;
	logic [15:0] rpm_q;
	logic [6:0]  wms_q;
	logic        req_q;
	logic        relay_q;
	logic [15:0] timer_q;

	// Arithmetic operands
	logic [QUOT_W-1:0] product_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W:0]    den_x2;

	// Result register
	logic        out_valid_q;
	logic        relay_out_q;
	logic [15:0] rpm_out_q;
	logic [6:0]  wms_out_q;
	logic        req_out_q;

	logic [16:0]       count_sum;
	logic [15:0]       count_nx;
	logic              div_load;
	logic [QUOT_W-1:0] quot;
	logic              div_more;
	logic [32:0]       wid_prod;

	logic        timed_out;
	logic [15:0] rpm_eff;
	logic        low_rpm;
	logic        cut;
	logic [15:0] timer_nx;
	logic        relay_nx;

	assign count_sum = {1'b0, count_q} + 17'(pulses_in_q);
	assign count_nx  = count_sum[16] ? 16'hFFFF : count_sum[15:0];
	assign den_x2    = (DEN_W + 1)'(elapsed_q) * (DEN_W + 1)'(CYLINDERS);
	assign wid_prod  = 33'(width_us_q) * 33'(WID_RECIP);

	assign stat.no_close = elapsed_q < cfg.rpm_window_ms;
	assign stat.empty    = count_q == 16'd0;
	assign stat.div_more = div_more;
	assign stat.out_busy = out_valid_q && out_stall;

	assign div_load = ctrl.op == OP_DIV_RPM;

	elacc_div #(
		.DEN_W(DEN_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (div_load),
		.div_step(ctrl.op == OP_DIV_STEP),
		.num     (product_q),
		.den     (den_q),
		.bits    (RPM_DIV_BITS),
		.quot    (quot),
		.more    (div_more)
	);

	// Timeout forcing, cutoff decision and relay timing of the closing step.
	always_comb begin
		timed_out = since_q > cfg.pulse_timeout_ms;
		rpm_eff   = timed_out ? 16'd0 : rpm_q;
		low_rpm   = rpm_eff < {2'b00, cfg.rpm_low_limit};
		cut       = ((tps_in_q > cfg.tps_high_pct) || (map_in_q > cfg.map_high_pct)) && low_rpm
			|| (rpm_eff < {2'b00, cfg.rpm_idle_limit});
		if (cut != req_q) begin
			timer_nx = 16'd0;
		end else begin
			timer_nx = (timer_q == 16'hFFFF) ? timer_q : timer_q + 16'd1;
		end
		relay_nx = relay_q;
		if (cut && relay_q && (timer_nx >= cfg.cutoff_delay_ms)) begin
			relay_nx = 1'b0;
		end else if (!cut && !relay_q && (timer_nx >= cfg.restore_delay_ms)) begin
			relay_nx = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			map_in_q    <= map_pct;
			tps_in_q    <= tps_pct;
			pulses_in_q <= pulses_ended;
			width_in_q  <= pulse_width_us;
		end
		if (ctrl.op == OP_MUL) begin
			product_q <= QUOT_W'(count_q) * QUOT_W'(RPM_SCALE);
			den_q     <= den_x2[DEN_W:1];
		end
		if (ctrl.op == OP_FINISH) begin
			relay_out_q <= relay_nx;
			rpm_out_q   <= rpm_eff;
			wms_out_q   <= wms_q;
			req_out_q   <= cut;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q   <= '0;
			count_q     <= '0;
			width_us_q  <= '0;
			since_q     <= 16'hFFFF;
			rpm_q       <= '0;
			wms_q       <= '0;
			req_q       <= 1'b0;
			relay_q     <= 1'b1;
			timer_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (ctrl.op)
				OP_ACCUM: begin
					if (pulses_in_q != 3'd0) begin
						count_q    <= count_nx;
						width_us_q <= width_in_q;
						since_q    <= '0;
					end else if (since_q != 16'hFFFF) begin
						since_q <= since_q + 16'd1;
					end
					if (elapsed_q != 10'h3FF) begin
						elapsed_q <= elapsed_q + 10'd1;
					end
				end
				OP_STORE_RPM: begin
					rpm_q <= (quot[QUOT_W-1:16] != '0) ? 16'hFFFF : quot[15:0];
				end
				OP_STORE_WID: begin
					wms_q     <= wid_prod[WID_SHIFT +: 7];
					count_q   <= '0;
					elapsed_q <= '0;
				end
				OP_CLEAR_EMPTY: begin
					rpm_q     <= '0;
					count_q   <= '0;
					elapsed_q <= '0;
				end
				OP_FINISH: begin
					rpm_q   <= rpm_eff;
					req_q   <= cut;
					timer_q <= timer_nx;
					relay_q <= relay_nx;
				end
				default: ;
			endcase
			// The program waits for a free result register before it finishes.
			if (ctrl.op == OP_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign relay_on       = relay_out_q;
	assign engine_rpm     = rpm_out_q;
	assign pulse_width_ms = wms_out_q;
	assign cutoff_request = req_out_q;

endmodule

@@ sv/engine_load_ac_cutoff_controller_unit.sv @@
// ----------------------------------------------------------------------------
// engine_load_ac_cutoff_controller_unit
// Air-conditioning compressor cutoff from engine speed, load and throttle.
// ----------------------------------------------------------------------------
// Each input transfer is one millisecond tick and gives exactly one result
// transfer. A tick that does not close the counting window passes the
// accumulate, check, wait and finish steps, and a tick that closes an empty
// window also passes the multiply step and a step that clears the window. A
// tick that closes a window with pulses in it runs the serial divider for the
// RPM, which yields one quotient bit per cycle; the pulse width in milliseconds
// comes from a reciprocal multiplication in a single step. The input is
// accepted again in the cycle after the result register is loaded.
// The result sits in an output register, so the next tick is
// accepted while an earlier result still waits to be taken; that tick then
// holds before its finishing step until the register is free. Configuration
// registers lie at byte addresses 4*i and should only be written while no
// tick is in progress.
module engine_load_ac_cutoff_controller_unit #(
	parameter int CYLINDERS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [elacc_pkg::ADDR_W-1:0]  paddr,
	input  logic [elacc_pkg::DATA_W-1:0]  pwdata,
	output logic [elacc_pkg::DATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [6:0]                    map_pct,
	input  logic [6:0]                    tps_pct,
	input  logic [2:0]                    pulses_ended,
	input  logic [15:0]                   pulse_width_us,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          relay_on,
	output logic [15:0]                   engine_rpm,
	output logic [6:0]                    pulse_width_ms,
	output logic                          cutoff_request
);
	import elacc_pkg::*;

	cfg_t  cfg;
	ctrl_t ctrl;
	stat_t stat;
	logic  in_fire;

	assign in_fire = in_valid && !in_stall;

	elacc_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	elacc_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.stat    (stat),
		.ctrl    (ctrl),
		.in_stall(in_stall)
	);

	elacc_dp #(
		.CYLINDERS(CYLINDERS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.ctrl          (ctrl),
		.in_fire       (in_fire),
		.map_pct       (map_pct),
		.tps_pct       (tps_pct),
		.pulses_ended  (pulses_ended),
		.pulse_width_us(pulse_width_us),
		.out_stall     (out_stall),
		.stat          (stat),
		.out_valid     (out_valid),
		.relay_on      (relay_on),
		.engine_rpm    (engine_rpm),
		.pulse_width_ms(pulse_width_ms),
		.cutoff_request(cutoff_request)
	);

endmodule

@@ dv/tb_engine_load_ac_cutoff_controller_unit.sv @@
// ----------------------------------------------------------------------------
// tb_engine_load_ac_cutoff_controller_unit
// Self-checking bench for the AC cutoff controller. Millisecond ticks are
// driven through the valid/stall input channel. A cycle-free model of the
// speed estimate, request logic and relay timers predicts every result
// transfer, and each result is compared field by field with the oldest
// prediction. The registers are reprogrammed between phases over the APB
// port and read back. Phases cover the field extremes, a zero window with
// zero delays, pulse trains at random rates with dropouts under lowest,
// highest and random settings, and the longest window, set with every bit.
// ----------------------------------------------------------------------------
module tb_engine_load_ac_cutoff_controller_unit;
	import elacc_pkg::*;

	localparam int CYLINDERS = 4;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;

	typedef struct packed {
		logic [6:0]  map;
		logic [6:0]  tps;
		logic [2:0]  pulses;
		logic [15:0] width_us;
	} tick_t;

	typedef struct packed {
		logic        relay;
		logic [15:0] rpm;
		logic [6:0]  width_ms;
		logic        request;
	} result_t;

	typedef enum {SET_LOWEST, SET_HIGHEST, SET_MIXED} setting_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [6:0]        map_pct = '0;
	logic [6:0]        tps_pct = '0;
	logic [2:0]        pulses_ended = '0;
	logic [15:0]       pulse_width_us = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              relay_on;
	logic [15:0]       engine_rpm;
	logic [6:0]        pulse_width_ms;
	logic              cutoff_request;

	engine_load_ac_cutoff_controller_unit #(
		.CYLINDERS(CYLINDERS)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.map_pct(map_pct), .tps_pct(tps_pct),
		.pulses_ended(pulses_ended), .pulse_width_us(pulse_width_us),
		.out_valid(out_valid), .out_stall(out_stall),
		.relay_on(relay_on), .engine_rpm(engine_rpm),
		.pulse_width_ms(pulse_width_ms), .cutoff_request(cutoff_request)
	);

	always #4 clk = ~clk;

	// Controller state as predicted, starting from its reset values.
	cfg_t        settings = '{RST_TPS_HIGH, RST_MAP_HIGH, RST_RPM_LOW, RST_RPM_IDLE,
	                          RST_CUT_DELAY, RST_REST_DELAY, RST_PULSE_TMO, RST_RPM_WINDOW};
	int unsigned win_elapsed = 0;
	int unsigned win_pulses = 0;
	int unsigned since_pulse = 65535;
	int unsigned relay_timer = 0;
	logic [15:0] last_width_us = '0;
	logic [15:0] rpm_now = '0;
	logic [6:0]  width_ms_now = '0;
	logic        cut_req = 1'b0;
	logic        relay_closed = 1'b1;

	result_t     pending_results[$];
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned stall_left = 0;
	bit          tx_idling = 1'b1;
	bit          rx_idling = 1'b1;

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			fail_count++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	task automatic predict_tick_result(input tick_t t, output result_t r);
		longint unsigned span;
		longint unsigned quot;
		logic            low_rpm;
		logic            cut;
		if (t.pulses != 0) begin
			win_pulses = win_pulses + t.pulses;
			if (win_pulses > 65535)
				win_pulses = 65535;
			last_width_us = t.width_us;
			since_pulse = 0;
		end else if (since_pulse < 65535) begin
			since_pulse++;
		end
		if (win_elapsed < 1023)
			win_elapsed++;
		if (win_elapsed >= settings.rpm_window_ms) begin
			if (win_pulses != 0) begin
				span = longint'(win_elapsed) * CYLINDERS / 2;
				if (span == 0)
					span = 1;
				quot = longint'(win_pulses) * 60000 / span;
				rpm_now = (quot > 65535) ? 16'hFFFF : quot[15:0];
				width_ms_now = 7'(last_width_us / 1000);
			end else begin
				rpm_now = '0;
			end
			win_pulses = 0;
			win_elapsed = 0;
		end
		if (since_pulse > settings.pulse_timeout_ms)
			rpm_now = '0;
		low_rpm = rpm_now < settings.rpm_low_limit;
		cut = ((t.tps > settings.tps_high_pct || t.map > settings.map_high_pct) && low_rpm)
			|| rpm_now < settings.rpm_idle_limit;
		if (cut != cut_req) begin
			cut_req = cut;
			relay_timer = 0;
		end else if (relay_timer < 65535) begin
			relay_timer++;
		end
		if (cut_req && relay_closed && relay_timer >= settings.cutoff_delay_ms)
			relay_closed = 1'b0;
		else if (!cut_req && !relay_closed && relay_timer >= settings.restore_delay_ms)
			relay_closed = 1'b1;
		r = '{relay_closed, rpm_now, width_ms_now, cut_req};
	endtask

	function automatic logic [31:0] reg_value(input reg_idx_t idx);
		case (idx)
			REG_TPS_HIGH:   return 32'(settings.tps_high_pct);
			REG_MAP_HIGH:   return 32'(settings.map_high_pct);
			REG_RPM_LOW:    return 32'(settings.rpm_low_limit);
			REG_RPM_IDLE:   return 32'(settings.rpm_idle_limit);
			REG_CUT_DELAY:  return 32'(settings.cutoff_delay_ms);
			REG_REST_DELAY: return 32'(settings.restore_delay_ms);
			REG_PULSE_TMO:  return 32'(settings.pulse_timeout_ms);
			default:        return 32'(settings.rpm_window_ms);
		endcase
	endfunction

	// Writes one register, then reads it back; psel stays high between the two.
	task automatic cfg_set(input reg_idx_t idx, input logic [31:0] raw);
		case (idx)
			REG_TPS_HIGH:   settings.tps_high_pct = raw[6:0];
			REG_MAP_HIGH:   settings.map_high_pct = raw[6:0];
			REG_RPM_LOW:    settings.rpm_low_limit = raw[13:0];
			REG_RPM_IDLE:   settings.rpm_idle_limit = raw[13:0];
			REG_CUT_DELAY:  settings.cutoff_delay_ms = raw[15:0];
			REG_REST_DELAY: settings.restore_delay_ms = raw[15:0];
			REG_PULSE_TMO:  settings.pulse_timeout_ms = raw[15:0];
			default:        settings.rpm_window_ms = raw[9:0];
		endcase
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= raw;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		check_field("register readback", reg_value(idx), prdata);
	endtask

	function automatic logic [31:0] noisy(input int unsigned v, input int unsigned w);
		logic [31:0] junk;
		junk = $urandom;
		if ($urandom_range(3) == 0)
			return v | (junk << w);
		return v;
	endfunction

	function automatic int unsigned pick_value(input setting_mode_t mode,
			input int unsigned lo, input int unsigned hi, input int unsigned typ);
		case (mode)
			SET_LOWEST:  return lo;
			SET_HIGHEST: return hi;
			default: begin
				case ($urandom_range(7))
					0:       return lo;
					1:       return hi;
					default: return $urandom_range(typ, lo);
				endcase
			end
		endcase
	endfunction

	function automatic logic [6:0] pick_percent();
		if ($urandom_range(4) == 0)
			return 7'($urandom_range(127, 101));
		return 7'($urandom_range(100));
	endfunction

	task automatic program_settings(input setting_mode_t mode);
		cfg_set(REG_TPS_HIGH,   noisy(pick_value(mode, 0, 127, 100), 7));
		cfg_set(REG_MAP_HIGH,   noisy(pick_value(mode, 0, 127, 100), 7));
		cfg_set(REG_RPM_LOW,    noisy(pick_value(mode, 0, 16383, 4000), 14));
		cfg_set(REG_RPM_IDLE,   noisy(pick_value(mode, 0, 16383, 2500), 14));
		cfg_set(REG_CUT_DELAY,  noisy(pick_value(mode, 0, 65535, 40), 16));
		cfg_set(REG_REST_DELAY, noisy(pick_value(mode, 0, 65535, 60), 16));
		cfg_set(REG_PULSE_TMO,  noisy(pick_value(mode, 0, 65535, 80), 16));
		cfg_set(REG_RPM_WINDOW, noisy(pick_value(mode, 0, 40, 25), 10));
	endtask

	// Valid is left high after a transfer unless a gap follows, so that
	// back-to-back ticks never lower and raise it in the same step.
	task automatic send_tick(input tick_t t);
		result_t r;
		in_valid <= 1'b1;
		map_pct <= t.map;
		tps_pct <= t.tps;
		pulses_ended <= t.pulses;
		pulse_width_us <= t.width_us;
		do @(posedge clk); while (in_stall);
		predict_tick_result(t, r);
		pending_results.push_back(r);
		if (tx_idling && $urandom_range(3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(16, 1)) @(posedge clk);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Pulse train at a fixed period with held pedal and load, broken by
	// dropouts and the odd stray pulse.
	task automatic run_engine(input int unsigned count, input int unsigned period);
		tick_t       t;
		int unsigned phase_tick;
		int unsigned dropout;
		logic [6:0]  held_map;
		logic [6:0]  held_tps;
		held_map = pick_percent();
		held_tps = pick_percent();
		phase_tick = 0;
		dropout = 0;
		repeat (count) begin
			if ($urandom_range(19) == 0)
				held_map = pick_percent();
			if ($urandom_range(19) == 0)
				held_tps = pick_percent();
			if (dropout == 0 && $urandom_range(39) == 0)
				dropout = $urandom_range(120, 1);
			t.map = held_map;
			t.tps = held_tps;
			t.pulses = '0;
			t.width_us = ($urandom_range(3) == 0) ? 16'($urandom)
				: 16'($urandom_range(20000));
			phase_tick++;
			if (dropout != 0)
				dropout--;
			else if (phase_tick % period == 0)
				t.pulses = ($urandom_range(4) == 0) ? 3'($urandom_range(7, 1)) : 3'd1;
			else if ($urandom_range(49) == 0)
				t.pulses = 3'($urandom);
			send_tick(t);
		end
	endtask

	task automatic test_input_extremes();
		send_tick('{7'd0,   7'd0,   3'd0, 16'd0});
		send_tick('{7'd127, 7'd127, 3'd7, 16'd65535});
		send_tick('{7'd100, 7'd100, 3'd1, 16'd999});
		send_tick('{7'd101, 7'd101, 3'd2, 16'd1000});
		send_tick('{7'd0,   7'd127, 3'd3, 16'd21845});
		send_tick('{7'd127, 7'd0,   3'd4, 16'd43690});
		send_tick('{7'd64,  7'd64,  3'd5, 16'd1});
		send_tick('{7'd1,   7'd1,   3'd6, 16'd32768});
		send_tick('{7'd50,  7'd50,  3'd0, 16'd65535});
		send_tick('{7'd80,  7'd80,  3'd1, 16'd0});
		settle();
	endtask

	// Every tick closes the window; the relay follows the request at once,
	// and a single tick without a pulse already times the speed out.
	task automatic test_zero_window();
		cfg_set(REG_RPM_WINDOW, 32'd0);
		cfg_set(REG_CUT_DELAY, 32'd0);
		cfg_set(REG_REST_DELAY, 32'd0);
		cfg_set(REG_PULSE_TMO, 32'd0);
		cfg_set(REG_TPS_HIGH, 32'd100);
		cfg_set(REG_MAP_HIGH, 32'd100);
		cfg_set(REG_RPM_LOW, 32'd16383);
		cfg_set(REG_RPM_IDLE, 32'd0);
		send_tick('{7'd127, 7'd127, 3'd7, 16'd65535});
		send_tick('{7'd0,   7'd0,   3'd0, 16'd0});
		send_tick('{7'd101, 7'd0,   3'd1, 16'd1000});
		send_tick('{7'd101, 7'd0,   3'd0, 16'd1999});
		send_tick('{7'd0,   7'd101, 3'd0, 16'd0});
		send_tick('{7'd100, 7'd100, 3'd0, 16'd0});
		send_tick('{7'd0,   7'd0,   3'd2, 16'd64999});
		send_tick('{7'd0,   7'd0,   3'd0, 16'd0});
		send_tick('{7'd127, 7'd0,   3'd3, 16'd1});
		send_tick('{7'd0,   7'd0,   3'd0, 16'd0});
		send_tick('{7'd0,   7'd127, 3'd4, 16'd30000});
		send_tick('{7'd0,   7'd0,   3'd0, 16'd0});
		settle();
	endtask

	task automatic test_random_operation();
		for (int p = 0; p < 8; p++) begin
			tx_idling = ($urandom_range(3) != 0);
			rx_idling = ($urandom_range(3) != 0);
			program_settings(p == 0 ? SET_LOWEST : (p == 1 ? SET_HIGHEST : SET_MIXED));
			run_engine(30, $urandom_range(40, 1));
			settle();
		end
	endtask

	task automatic test_long_window();
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		program_settings(SET_MIXED);
		cfg_set(REG_PULSE_TMO, 32'h0000_FFFF);
		// The field keeps the low 10 bits, 1023 ms; the window closes at 1023 ms.
		cfg_set(REG_RPM_WINDOW, 32'hFFFF_FFFF);
		run_engine(1040, $urandom_range(30, 2));
		settle();
	endtask

	always @(posedge clk) begin
		if (stall_left == 0 && rx_idling && $urandom_range(7) == 0)
			stall_left = $urandom_range(16, 1);
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				$error("result transfer with no tick outstanding");
			end else begin
				want = pending_results.pop_front();
				check_field("relay_on", want.relay, relay_on);
				check_field("engine_rpm", want.rpm, engine_rpm);
				check_field("pulse_width_ms", want.width_ms, pulse_width_ms);
				check_field("cutoff_request", want.request, cutoff_request);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_input_extremes();
		test_zero_window();
		test_random_operation();
		test_long_window();
		repeat (64) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
